/* rtl/mpcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_pkg: shared types and constants
// Command and result records, request codes and sizing defaults for the
// multichannel pwm compare scheduler.
// ----------------------------------------------------------------------------
package mpcs_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned PIN_W        = 8;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // request codes on the req_type port
  localparam logic [1:0] REQ_SET_DUTY = 2'd0;
  localparam logic [1:0] REQ_PERIOD   = 2'd1;
  localparam logic [1:0] REQ_COMPARE  = 2'd2;

  // classified command operations
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_START = 2'd1,
    OP_CMP   = 2'd2,
    OP_NONE  = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [2:0]  chan;
    logic [15:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  pin_mask;
    logic        compare_enable;
    logic [15:0] compare_preload;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FINAL = 2'd2,
    ST_DONE  = 2'd3
  } back_state_t;

endpackage : mpcs_pkg
`default_nettype wire

/* rtl/mpcs_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_fifo: small register queue
// Fixed-depth first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module mpcs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule : mpcs_fifo
`default_nettype wire

/* rtl/mpcs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_front: request classifier
// Decodes the request type, turns set-duty requests for out-of-range channels
// into no-ops and packs the operand into a command for the back end.
// ----------------------------------------------------------------------------
module mpcs_front #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        req_type,
  input  wire logic [2:0]        channel,
  input  wire logic [15:0]       duty_ticks,
  input  wire logic [15:0]       timer_value,
  output logic                   q_push,
  input  wire logic              q_full,
  output mpcs_pkg::cmd_t         cmd
);

  import mpcs_pkg::*;

  logic chan_ok;

  assign chan_ok = (32'(channel) < CHANNELS);
  assign q_push  = push;
  assign full    = q_full;

  always_comb begin
    cmd.chan = channel;
    cmd.arg  = duty_ticks;
    case (req_type)
      REQ_SET_DUTY: cmd.op = chan_ok ? OP_SET : OP_NONE;
      REQ_PERIOD:   cmd.op = OP_START;
      REQ_COMPARE: begin
        cmd.op  = OP_CMP;
        cmd.arg = timer_value;
      end
      default:      cmd.op = OP_NONE;
    endcase
  end

endmodule : mpcs_front
`default_nettype wire

/* rtl/mpcs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_back: channel scan engine
// Executes commands; start and compare commands scan one channel per cycle to
// update on-times and pins and schedule the next compare; all emit a result.
// ----------------------------------------------------------------------------
module mpcs_back #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mpcs_pkg::cmd_t    cmd,
  input  wire logic              cmd_empty,
  output logic                   cmd_pop,
  output mpcs_pkg::res_t         res,
  input  wire logic              res_full,
  output logic                   res_push
);

  import mpcs_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  back_state_t state;
  back_state_t state_next;

  cmd_t              cur;
  logic [IDX_W-1:0]  idx;
  logic [15:0]       shortest;
  logic [15:0]       requested [CHANNELS];
  logic [15:0]       active [CHANNELS];
  logic [CHANNELS-1:0] pins;
  logic              armed;
  logic [15:0]       preload;

  logic              last_idx;
  logic [15:0]       req_i;
  logic [15:0]       act_i;
  logic [15:0]       new_act;
  logic              new_pin;
  logic [CHANNELS+7:0] pins_wide;

  assign last_idx  = (idx == IDX_W'(CHANNELS - 1));
  assign req_i     = requested[idx];
  assign act_i     = active[idx];
  assign pins_wide = (CHANNELS + 8)'(pins);

  // per-channel update for the scan step
  always_comb begin
    if (cur.op == OP_START) begin
      new_act = req_i;
      new_pin = pins[idx] | (req_i != '0);
    end else begin
      new_act = act_i;
      new_pin = pins[idx] & !(act_i <= cur.arg);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          state_next = (cmd.op == OP_START || cmd.op == OP_CMP) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN:  if (last_idx) state_next = ST_FINAL;
      ST_FINAL: state_next = ST_DONE;
      ST_DONE:  if (!res_full) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop             = (state == ST_IDLE) && !cmd_empty;
    res_push            = (state == ST_DONE) && !res_full;
    res.pin_mask        = pins_wide[7:0];
    res.compare_enable  = armed;
    res.compare_preload = preload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command capture and scan datapath
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur      <= cmd;
      idx      <= '0;
      shortest <= TICK_MAX;
    end else if (state == ST_SCAN && !last_idx) begin
      idx <= idx + 1'b1;
    end
    if (state == ST_SCAN && new_pin && (new_act < shortest)) begin
      shortest <= new_act;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        requested[i] <= '0;
        active[i]    <= '0;
      end
      pins    <= '0;
      armed   <= 1'b0;
      preload <= '0;
    end else begin
      if (cmd_pop && cmd.op == OP_SET) begin
        requested[IDX_W'(cmd.chan)] <= cmd.arg;
      end
      if (state == ST_SCAN) begin
        active[idx] <= new_act;
        pins[idx]   <= new_pin;
      end
      if (state == ST_FINAL) begin
        if (shortest == '0 || shortest == TICK_MAX) begin
          armed <= 1'b0;
        end else begin
          armed   <= 1'b1;
          preload <= TICK_MAX - shortest;
        end
      end
    end
  end

`ifndef SYNTH
  // an armed compare always carries a preload strictly inside the tick range
  a_preload_range: assert property (@(posedge clk) disable iff (rst)
    armed |-> (preload != '0 && preload != TICK_MAX))
    else $error("armed compare with out-of-range preload");

  // the scan pointer never leaves the channel range while scanning
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (32'(idx) < CHANNELS))
    else $error("scan index beyond channel count");

  // only period-start and compare commands are scanned
  a_scan_op: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cur.op == OP_START || cur.op == OP_CMP))
    else $error("scan running for a command that needs none");

  // a popped command always leads to work, never straight back to idle
  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state != ST_IDLE))
    else $error("command popped but engine stayed idle");
`endif

endmodule : mpcs_back
`default_nettype wire

/* rtl/multichannel_pwm_compare_scheduler_core.sv */
`default_nettype none
// set-duty and unused requests go from idle to the done state and their result;
//   period-start and compare requests also pass the scan and final states,
//   scanning one channel per cycle; a new command is taken only once the last
//   result is pushed, which waits while the result queue is full
// reset: on-times, pins, compare arm and preload cleared, both queues emptied
// ----------------------------------------------------------------------------
// multichannel_pwm_compare_scheduler_core: multi-channel pwm scheduler
// Shadowed duty registers per channel, period-start latch, compare-driven pin
// clear and next-compare preload computation.
// ----------------------------------------------------------------------------
module multichannel_pwm_compare_scheduler_core #(
  parameter int unsigned CHANNELS = mpcs_pkg::CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request side
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  channel,
  input  wire logic [15:0] duty_ticks,
  input  wire logic [15:0] timer_value,
  // result side
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       pin_mask,
  output logic             compare_enable,
  output logic [15:0]      compare_preload
);

  import mpcs_pkg::*;

  // front end to command queue
  logic q_push;
  logic q_full;
  cmd_t front_cmd;

  // command queue to back end
  cmd_t q_cmd;
  logic [$bits(cmd_t)-1:0] q_cmd_bits;
  logic q_empty;
  logic q_pop;

  // back end to result queue
  res_t back_res;
  logic [$bits(res_t)-1:0] out_bits;
  res_t out_res;
  logic res_full;
  logic res_push;

  // classify each transaction and turn bad-channel set-duty requests into no-ops
  mpcs_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .channel     (channel),
    .duty_ticks  (duty_ticks),
    .timer_value (timer_value),
    .q_push      (q_push),
    .q_full      (q_full),
    .cmd         (front_cmd)
  );

  // short command queue decouples intake from the channel scan
  mpcs_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_cmd_bits),
    .empty (q_empty)
  );

  assign q_cmd = cmd_t'(q_cmd_bits);

  // scan engine: holds on-times, pins and compare schedule
  mpcs_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res       (back_res),
    .res_full  (res_full),
    .res_push  (res_push)
  );

  // result queue lets the engine finish while the consumer stalls
  mpcs_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_bits),
    .empty (empty)
  );

  assign out_res         = res_t'(out_bits);
  assign pin_mask        = out_res.pin_mask;
  assign compare_enable  = out_res.compare_enable;
  assign compare_preload = out_res.compare_preload;

endmodule : multichannel_pwm_compare_scheduler_core
`default_nettype wire
